// ===== design/slt_pkg.sv =====
// Shared widths, register codes and handshake types for the Sauvola threshold block.
`timescale 1ns / 1ps
package slt_pkg;

  localparam int PIX_W = 8;
  localparam int WS_W = 5;
  localparam int K_W = 16;
  localparam int PR_W = 8;
  localparam int DIM_W = 11;
  localparam int OUT_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_HEIGHT = 1024;

  // running sums
  localparam int CS_W = 13;
  localparam int CQ_W = 21;
  localparam int WSUM_W = 18;
  localparam int WSQ_W = 26;

  // threshold arithmetic
  localparam int WIN_W = 6;
  localparam int N_W = 2 * WIN_W;
  localparam int NN_W = 2 * N_W;
  localparam int NQ_W = N_W + WSQ_W;
  localparam int DV_W = NQ_W + 16;
  localparam int RT_W = DV_W / 2;
  localparam int KS_W = K_W + RT_W;
  localparam int KP_W = K_W + PR_W;
  localparam int M_W = KS_W + 3;
  localparam int MLO_W = M_W / 2;
  localparam int MHI_W = M_W - MLO_W;
  localparam int NP_W = N_W + PR_W;
  localparam int CN_W = NP_W + PIX_W;
  localparam int SM_W = 64;
  localparam int STEP_W = $clog2(DV_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAUVOLA_K = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_RANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd4;

  localparam logic [WS_W-1:0] RST_WINDOW_SIZE = 5'd15;
  localparam logic [K_W-1:0] RST_SAUVOLA_K = 16'd13107;
  localparam logic [PR_W-1:0] RST_PIXEL_RANGE = 8'd255;
  localparam logic [DIM_W-1:0] RST_IMAGE_DIM = 11'd1024;

  typedef struct packed {
    logic start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

// ===== design/slt_pix_if.sv =====
// Pixel input channel interface.
`timescale 1ns / 1ps
interface slt_pix_if import slt_pkg::*; ();
  logic valid;
  logic ready;
  logic [PIX_W-1:0] pixel;
  logic frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== design/slt_res_if.sv =====
// Result channel interface: decided pixel coordinates and threshold bit.
`timescale 1ns / 1ps
interface slt_res_if import slt_pkg::*; ();
  logic valid;
  logic ready;
  logic [OUT_W-1:0] out_row;
  logic [OUT_W-1:0] out_col;
  logic out_bit;
  modport source (output valid, output out_row, output out_col, output out_bit, input ready);
  modport sink (input valid, input out_row, input out_col, input out_bit, output ready);
endinterface

// ===== design/slt_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module slt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/slt_div.sv =====
// Restoring divider, one quotient bit per cycle, dividend left-aligned.
`timescale 1ns / 1ps
module slt_div import slt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  input  logic [DV_W-1:0]   dividend,
  input  logic [NN_W-1:0]   divisor,
  output logic [DV_W-1:0]   quotient,
  output logic [NN_W-1:0]   remainder,
  output logic              done
);
  logic [DV_W-1:0] dvd;
  logic [NN_W-1:0] dvs;
  logic [STEP_W-1:0] cnt;
  logic busy;
  logic [NN_W:0] trial;
  logic fits;

  assign trial = {remainder, dvd[DV_W-1]};
  assign fits = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= dividend;
      dvs <= divisor;
      remainder <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[DV_W-2:0], 1'b0};
      remainder <= fits ? NN_W'(trial - {1'b0, dvs}) : trial[NN_W-1:0];
      quotient <= {quotient[DV_W-2:0], fits};
    end
  end
endmodule

// ===== design/slt_sqrt.sv =====
// Integer square root, two radicand bits per cycle, root rounded down.
`timescale 1ns / 1ps
module slt_sqrt import slt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DV_W-1:0] radicand,
  output logic [RT_W-1:0] root,
  output logic            done
);
  localparam int CNT_W = $clog2(RT_W + 1);
  localparam int REM_W = RT_W + 3;

  logic [DV_W-1:0] xs;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] trial;
  logic fits;

  assign shifted = {rem[RT_W:0], xs[DV_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(RT_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs <= radicand;
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      xs <= {xs[DV_W-3:0], 2'b00};
      rem <= fits ? shifted - trial : shifted;
      root <= {root[RT_W-2:0], fits};
    end
  end
endmodule

// ===== design/sauvola_local_threshold_top.sv =====
// Sauvola local threshold: line store, column sums, sequencer and threshold arithmetic.
//
// Usage: grey pixels enter in raster order on the pix channel (valid/ready); a beat with
// frame_start high restarts the row and column counters. For every pixel whose odd
// w-by-w window lies inside a frame wider and taller than w, one beat leaves on the res channel with the
// window centre's row, column and the Sauvola decision bit. Border centres give no beat.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it only
// while the block is idle.
// Timing: one pixel at a time. For a pixel that decides nothing, two remainders for the
// line-store slot and ring slot go through the shared 11-step divider, then follow one
// line-store read and one read-modify-write of the column-sum memory. A pixel that decides
// a centre also runs the 54-step variance division and the 27-step square root.
// Reset clears counters, window sums, column-sum fill count and the column ring; no
// clearing pass runs, the column memory is tracked by a fill count.
// A stalled receiver holds the result register; the next pixel is still taken and runs
// until its own result is ready, then waits for the register to drain.
`timescale 1ns / 1ps
module sauvola_local_threshold_top import slt_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_WINDOW = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  slt_pix_if.sink               pix,
  slt_res_if.source             res
);
  localparam int CA_W = $clog2(MAX_WIDTH);
  localparam int FILL_W = $clog2(MAX_WIDTH + 1);
  localparam int LS_DEPTH = (MAX_WINDOW - 1) * MAX_WIDTH;
  localparam int LS_AW = $clog2(LS_DEPTH);
  localparam int SL_W = $clog2(MAX_WINDOW - 1);
  localparam int RS_W = $clog2(MAX_WINDOW);
  localparam int COL_W = CS_W + CQ_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SLOT = 4'd1;
  localparam logic [3:0] S_RS = 4'd2;
  localparam logic [3:0] S_LREAD = 4'd3;
  localparam logic [3:0] S_UPD = 4'd4;
  localparam logic [3:0] S_CENT = 4'd5;
  localparam logic [3:0] S_MUL = 4'd6;
  localparam logic [3:0] S_VDIV = 4'd7;
  localparam logic [3:0] S_SQRT = 4'd8;
  localparam logic [3:0] S_KMUL = 4'd9;
  localparam logic [3:0] S_MSUM = 4'd10;
  localparam logic [3:0] S_SMUL = 4'd11;
  localparam logic [3:0] S_CMP = 4'd12;
  localparam logic [3:0] S_EMIT = 4'd13;

  // configuration
  logic [WS_W-1:0] window_size;
  logic [K_W-1:0] sauvola_k;
  logic [PR_W-1:0] pixel_range;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= RST_WINDOW_SIZE;
      sauvola_k <= RST_SAUVOLA_K;
      pixel_range <= RST_PIXEL_RANGE;
      image_width <= RST_IMAGE_DIM;
      image_height <= RST_IMAGE_DIM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE: window_size <= cfg_data[WS_W-1:0];
        CFG_SAUVOLA_K: sauvola_k <= cfg_data[K_W-1:0];
        CFG_PIXEL_RANGE: pixel_range <= cfg_data[PR_W-1:0];
        CFG_IMAGE_WIDTH: image_width <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped working values
  logic [WIN_W-1:0] w_odd, w, h;
  logic [DIM_W-1:0] wd, ht, wm1;
  logic [PR_W-1:0] pr;

  always_comb begin
    w_odd = {1'b0, window_size | WS_W'(1)};
    if (w_odd < WIN_W'(3)) begin
      w = WIN_W'(3);
    end else if (w_odd > WIN_W'(MAX_WINDOW)) begin
      w = WIN_W'(MAX_WINDOW);
    end else begin
      w = w_odd;
    end
    h = w >> 1;
    wm1 = DIM_W'(w) - DIM_W'(1);
    if (image_width == '0) begin
      wd = DIM_W'(1);
    end else if ({2'b00, image_width} > (DIM_W+2)'(MAX_WIDTH)) begin
      wd = DIM_W'(MAX_WIDTH);
    end else begin
      wd = image_width;
    end
    if (image_height == '0) begin
      ht = DIM_W'(1);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      ht = DIM_W'(MAX_HEIGHT);
    end else begin
      ht = image_height;
    end
    pr = (pixel_range == '0) ? PR_W'(1) : pixel_range;
  end

  // sequencer state
  logic [3:0] state;
  logic launched;
  logic [DIM_W-1:0] row_count, col_count;
  logic [DIM_W-1:0] r, c;
  logic [PIX_W-1:0] p;
  logic [FILL_W-1:0] fill;
  logic [SL_W-1:0] slot;
  logic [RS_W-1:0] rs;
  logic [WSUM_W-1:0] window_sum;
  logic [WSQ_W-1:0] window_square_sum;
  logic [CS_W-1:0] ring_s [MAX_WINDOW];
  logic [CQ_W-1:0] ring_q [MAX_WINDOW];
  logic emit;
  logic [OUT_W-1:0] crow, ccol;
  logic [PIX_W-1:0] centre;
  logic [N_W-1:0] n;
  logic [NQ_W-1:0] nq, ss;
  logic [NN_W-1:0] nn;
  logic [NP_W-1:0] npp;
  logic [RT_W-1:0] sd;
  logic [KS_W-1:0] kd;
  logic [KP_W-1:0] kp;
  logic [CN_W-1:0] cn;
  logic [M_W-1:0] m;
  logic [WSUM_W+MLO_W-1:0] plo;
  logic [WSUM_W+MHI_W-1:0] phi;
  logic obit;

  logic accept;
  assign pix.ready = (state == S_IDLE);
  assign accept = pix.valid && pix.ready;

  // counters for the accepted beat
  logic [DIM_W-1:0] rc0, cc0, rc1, cc1;
  always_comb begin
    rc0 = pix.frame_start ? '0 : row_count;
    cc0 = pix.frame_start ? '0 : col_count;
    rc1 = rc0;
    cc1 = cc0;
    if (cc0 >= wd) begin
      cc1 = '0;
      rc1 = rc0 + DIM_W'(1);
    end
    if (rc1 >= ht) begin
      rc1 = '0;
    end
  end

  // shared divider, and the square root
  div_req_t div_req;
  logic [DV_W-1:0] div_dvd, div_quo;
  logic [NN_W-1:0] div_dvs, div_rem;
  logic div_done;
  logic sq_start, sq_done;
  logic [RT_W-1:0] sq_root;
  logic [NQ_W-1:0] d;

  assign d = (nq > ss) ? nq - ss : '0;

  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = STEP_W'(DIM_W);
    div_dvd = {r, (DV_W-DIM_W)'(0)};
    div_dvs = NN_W'(wm1);
    case (state)
      S_SLOT: begin
        div_req.start = !launched;
      end
      S_RS: begin
        div_req.start = !launched;
        div_dvd = {c, (DV_W-DIM_W)'(0)};
        div_dvs = NN_W'(w);
      end
      S_VDIV: begin
        div_req.start = !launched;
        div_req.steps = STEP_W'(DV_W);
        div_dvd = {d, 16'd0};
        div_dvs = nn;
      end
      default: ;
    endcase
  end

  assign sq_start = (state == S_SQRT) && !launched;

  slt_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .dividend(div_dvd), .divisor(div_dvs),
    .quotient(div_quo), .remainder(div_rem), .done(div_done)
  );

  slt_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(div_quo), .root(sq_root),
    .done(sq_done)
  );

  // memories
  logic ls_we, ls_re;
  logic [LS_AW-1:0] ls_waddr, ls_raddr, idx, cidx;
  logic [PIX_W-1:0] ls_rdata;
  logic col_we;
  logic [COL_W-1:0] col_wdata, col_rdata;
  logic [WIN_W-1:0] sl6, csl;

  assign idx = LS_AW'(slot) * LS_AW'(MAX_WIDTH) + LS_AW'(c);
  assign sl6 = WIN_W'(slot);
  assign csl = (sl6 >= h) ? sl6 - h : sl6 + w - WIN_W'(1) - h;
  assign cidx = LS_AW'(csl) * LS_AW'(MAX_WIDTH) + LS_AW'(c - DIM_W'(h));

  assign ls_we = (state == S_UPD);
  assign ls_waddr = idx;
  assign ls_re = (state == S_LREAD) || (state == S_UPD);
  assign ls_raddr = (state == S_UPD) ? cidx : idx;

  slt_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line_store (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(p), .re(ls_re), .raddr(ls_raddr),
    .rdata(ls_rdata)
  );

  assign col_we = (state == S_UPD);

  slt_ram #(.WIDTH(COL_W), .DEPTH(MAX_WIDTH)) u_column_store (
    .clk(clk), .we(col_we), .waddr(CA_W'(c)), .wdata(col_wdata), .re(accept),
    .raddr(CA_W'(cc1)), .rdata(col_rdata)
  );

  // column and window update
  logic use_prev;
  logic [CS_W-1:0] pre, tot, col_s_new, ring_s_rd;
  logic [CQ_W-1:0] pre2, tot2, col_q_new, ring_q_rd;
  logic [WSUM_W-1:0] wsum_next;
  logic [WSQ_W-1:0] wsq_next;
  logic emit_next;
  logic [DIM_W-1:0] c_inc, r_inc;

  always_comb begin
    use_prev = (r != '0) && (fill > FILL_W'(c));
    pre = use_prev ? col_rdata[COL_W-1:CQ_W] : '0;
    pre2 = use_prev ? col_rdata[CQ_W-1:0] : '0;
    tot = pre + CS_W'(p);
    tot2 = pre2 + CQ_W'(p * p);
    if (r >= wm1) begin
      col_s_new = tot - CS_W'(ls_rdata);
      col_q_new = tot2 - CQ_W'(ls_rdata * ls_rdata);
    end else begin
      col_s_new = tot;
      col_q_new = tot2;
    end
    col_wdata = {col_s_new, col_q_new};
    ring_s_rd = ring_s[rs];
    ring_q_rd = ring_q[rs];
    if (c == '0) begin
      wsum_next = WSUM_W'(tot);
      wsq_next = WSQ_W'(tot2);
    end else if (c < DIM_W'(w)) begin
      wsum_next = window_sum + WSUM_W'(tot);
      wsq_next = window_square_sum + WSQ_W'(tot2);
    end else begin
      wsum_next = window_sum + WSUM_W'(tot) - WSUM_W'(ring_s_rd);
      wsq_next = window_square_sum + WSQ_W'(tot2) - WSQ_W'(ring_q_rd);
    end
    emit_next = (DIM_W'(w) < wd) && (DIM_W'(w) < ht) && (r >= wm1) && (c >= wm1);
    c_inc = c + DIM_W'(1);
    r_inc = r + DIM_W'(1);
  end

  // result register
  logic load_out;
  assign load_out = (state == S_EMIT) && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.out_row <= crow;
      res.out_col <= ccol;
      res.out_bit <= obit;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      launched <= 1'b0;
      row_count <= '0;
      col_count <= '0;
      fill <= '0;
      window_sum <= '0;
      window_square_sum <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        ring_s[i] <= '0;
        ring_q[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          if (div_req.start) begin
            launched <= 1'b1;
          end else if (div_done) begin
            launched <= 1'b0;
            state <= S_RS;
          end
        end
        S_RS: begin
          if (div_req.start) begin
            launched <= 1'b1;
          end else if (div_done) begin
            launched <= 1'b0;
            state <= S_LREAD;
          end
        end
        S_LREAD: state <= S_UPD;
        S_UPD: begin
          window_sum <= wsum_next;
          window_square_sum <= wsq_next;
          ring_s[rs] <= tot;
          ring_q[rs] <= tot2;
          if (FILL_W'(c) == fill) begin
            fill <= fill + FILL_W'(1);
          end
          // advance raster position
          if (c_inc >= wd) begin
            col_count <= '0;
            row_count <= (r_inc >= ht) ? '0 : r_inc;
          end else begin
            col_count <= c_inc;
            row_count <= r;
          end
          state <= emit_next ? S_CENT : S_IDLE;
        end
        S_CENT: state <= S_MUL;
        S_MUL: state <= S_VDIV;
        S_VDIV: begin
          if (div_req.start) begin
            launched <= 1'b1;
          end else if (div_done) begin
            launched <= 1'b0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_start) begin
            launched <= 1'b1;
          end else if (sq_done) begin
            launched <= 1'b0;
            state <= S_KMUL;
          end
        end
        S_KMUL: state <= S_MSUM;
        S_MSUM: state <= S_SMUL;
        S_SMUL: state <= S_CMP;
        S_CMP: state <= S_EMIT;
        S_EMIT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      r <= rc1;
      c <= cc1;
      p <= pix.pixel;
    end
    if (state == S_SLOT && div_done) begin
      slot <= div_rem[SL_W-1:0];
    end
    if (state == S_RS && div_done) begin
      rs <= div_rem[RS_W-1:0];
    end
    if (state == S_UPD) begin
      crow <= OUT_W'(r - DIM_W'(h));
      ccol <= OUT_W'(c - DIM_W'(h));
      n <= N_W'(w * w);
      emit <= emit_next;
    end
    if (state == S_CENT) begin
      centre <= ls_rdata;
      nq <= NQ_W'(n * window_square_sum);
      nn <= NN_W'(n * (n - N_W'(1)));
    end
    if (state == S_MUL) begin
      ss <= NQ_W'(window_sum * window_sum);
      npp <= NP_W'(n * pr);
    end
    if (state == S_SQRT && sq_done) begin
      sd <= sq_root;
    end
    if (state == S_KMUL) begin
      kd <= KS_W'(sauvola_k * sd);
      kp <= KP_W'(sauvola_k * pr);
      cn <= CN_W'(centre * npp);
    end
    if (state == S_MSUM) begin
      m <= (M_W'(pr) << 24) + (M_W'(kd) << 1) - (M_W'(kp) << 8);
    end
    if (state == S_SMUL) begin
      plo <= (WSUM_W+MLO_W)'(window_sum * m[MLO_W-1:0]);
      phi <= (WSUM_W+MHI_W)'(window_sum * m[M_W-1:MLO_W]);
    end
    if (state == S_CMP) begin
      // bit is set when centre*256 exceeds floor(s*m / (n*pr*65536))
      obit <= (SM_W'(plo) + (SM_W'(phi) << MLO_W)) < (SM_W'(cn) << 24);
    end
  end

`ifndef ASSERT_OFF
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready |=> !pix.ready)
    else $error("second pixel taken while the first is in flight");

  a_idle_free: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !launched)
    else $error("arithmetic unit still launched at idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_WIDTH))
    else $error("column fill count beyond memory depth");

  a_emit_path: assert property (@(posedge clk) disable iff (rst)
    state == S_CENT |-> emit)
    else $error("centre decided for a border pixel");
`endif

endmodule
